@@ sv/cslc_pkg.sv @@
// cslc_pkg: shared types, character codes, class codes and keyword table
// for the c source lexical classifier. No dependencies.
`timescale 1ns / 1ps

package cslc_pkg;

  // lexer modes
  typedef enum logic [3:0] {
    MODE_NORMAL     = 4'd0,
    MODE_LONG       = 4'd1,
    MODE_SLASH      = 4'd2,
    MODE_CHAR       = 4'd3,
    MODE_CHAR_ESC   = 4'd4,
    MODE_STR        = 4'd5,
    MODE_STR_ESC    = 4'd6,
    MODE_PRE        = 4'd7,
    MODE_BLOCK      = 4'd8,
    MODE_BLOCK_STAR = 4'd9,
    MODE_LINE       = 4'd10
  } mode_e;

  // byte classes
  localparam logic [2:0] CLS_PLAIN   = 3'd0;
  localparam logic [2:0] CLS_KEYWORD = 3'd1;
  localparam logic [2:0] CLS_CHAR    = 3'd2;
  localparam logic [2:0] CLS_STRING  = 3'd3;
  localparam logic [2:0] CLS_PRE     = 3'd4;
  localparam logic [2:0] CLS_COMMENT = 3'd5;

  // character codes
  localparam logic [7:0] CH_HASH   = 8'h23;
  localparam logic [7:0] CH_SLASH  = 8'h2F;
  localparam logic [7:0] CH_STAR   = 8'h2A;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_NL     = 8'h0A;
  localparam logic [7:0] CH_SQUOTE = 8'h27;
  localparam logic [7:0] CH_DQUOTE = 8'h22;

  localparam int KW_COUNT = 32;

  // keywords, left justified, first character in the top byte
  localparam logic [63:0] KW_TEXT [KW_COUNT] = '{
    {"auto", 32'h0},     {"break", 24'h0},    {"case", 32'h0},     {"char", 32'h0},
    {"const", 24'h0},    "continue",          {"default", 8'h0},   {"do", 48'h0},
    {"double", 16'h0},   {"else", 32'h0},     {"enum", 32'h0},     {"extern", 16'h0},
    {"float", 24'h0},    {"for", 40'h0},      {"goto", 32'h0},     {"if", 48'h0},
    {"int", 40'h0},      {"long", 32'h0},     "register",          {"return", 16'h0},
    {"short", 24'h0},    {"signed", 16'h0},   {"sizeof", 16'h0},   {"static", 16'h0},
    {"struct", 16'h0},   {"switch", 16'h0},   {"typedef", 8'h0},   {"union", 24'h0},
    "unsigned",          {"void", 32'h0},     "volatile",          {"while", 24'h0}
  };

  localparam logic [3:0] KW_LEN [KW_COUNT] = '{
    4'd4, 4'd5, 4'd4, 4'd4, 4'd5, 4'd8, 4'd7, 4'd2,
    4'd6, 4'd4, 4'd4, 4'd6, 4'd5, 4'd3, 4'd4, 4'd2,
    4'd3, 4'd4, 4'd8, 4'd6, 4'd5, 4'd6, 4'd6, 4'd6,
    4'd6, 4'd6, 4'd7, 4'd5, 4'd8, 4'd4, 4'd8, 4'd5
  };

  // word buffer controls
  typedef struct packed {
    logic append;
    logic shift;
    logic clear;
  } word_ctl_t;

  // outcome of a non-word byte in normal text
  typedef struct packed {
    logic       emit;
    logic [2:0] cls;
    mode_e      mode;
  } other_t;

  function automatic logic is_alnum(input logic [7:0] b);
    return (b >= 8'h30 && b <= 8'h39) || (b >= 8'h41 && b <= 8'h5A) ||
           (b >= 8'h61 && b <= 8'h7A);
  endfunction

  // exact match of the first len bytes of a held word against the table
  function automatic logic kw_match(input logic [63:0] word, input logic [3:0] len);
    logic hit;
    logic eq;
    hit = 1'b0;
    for (int k = 0; k < KW_COUNT; k++) begin
      eq = (len == KW_LEN[k]);
      for (int i = 0; i < 8; i++) begin
        if (4'(i) < KW_LEN[k] && word[63-8*i -: 8] != KW_TEXT[k][63-8*i -: 8]) begin
          eq = 1'b0;
        end
      end
      hit = hit | eq;
    end
    return hit;
  endfunction

  function automatic other_t normal_other(input logic [7:0] b, input logic line_start);
    other_t o;
    o.emit = 1'b1;
    o.cls  = CLS_PLAIN;
    o.mode = MODE_NORMAL;
    if (b == CH_SQUOTE) begin
      o.cls  = CLS_CHAR;
      o.mode = MODE_CHAR;
    end else if (b == CH_DQUOTE) begin
      o.cls  = CLS_STRING;
      o.mode = MODE_STR;
    end else if (b == CH_HASH && line_start) begin
      o.cls  = CLS_PRE;
      o.mode = MODE_PRE;
    end else if (b == CH_SLASH) begin
      o.emit = 1'b0;
      o.mode = MODE_SLASH;
    end
    return o;
  endfunction

endpackage

@@ sv/cslc_word_buf.sv @@
// cslc_word_buf: hold buffer for a run of letters and digits, with keyword match.
// Depends on cslc_pkg.
`timescale 1ns / 1ps

module cslc_word_buf #(
  parameter int DEPTH = 8
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  cslc_pkg::word_ctl_t        ctl,
  input  logic [7:0]                 wr_byte,
  output logic [7:0]                 head,
  output logic [$clog2(DEPTH+1)-1:0] len,
  output logic                       full,
  output logic                       kw_hit
);
  import cslc_pkg::*;

  localparam int LW = $clog2(DEPTH + 1);
  localparam int IW = $clog2(DEPTH);

  logic [7:0]    word_r [DEPTH];
  logic [LW-1:0] len_r;
  logic [63:0]   held8;
  logic [3:0]    kw_len;

  // fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      len_r <= '0;
    end else if (ctl.clear) begin
      len_r <= '0;
    end else if (ctl.shift) begin
      len_r <= len_r - LW'(1);
    end else if (ctl.append) begin
      len_r <= len_r + LW'(1);
    end
  end

  // byte storage: release shifts toward the head, append writes at the tail
  always_ff @(posedge clk) begin
    if (ctl.shift) begin
      for (int i = 0; i < DEPTH - 1; i++) begin
        word_r[i] <= word_r[i+1];
      end
    end else if (ctl.append) begin
      word_r[len_r[IW-1:0]] <= wr_byte;
    end
  end

  // first eight bytes for the keyword compare
  always_comb begin
    for (int i = 0; i < 8; i++) begin
      held8[63-8*i -: 8] = word_r[i];
    end
  end

  assign kw_len = (len_r > LW'(8)) ? 4'd0 : len_r[3:0];
  assign kw_hit = kw_match(held8, kw_len);
  assign head   = word_r[0];
  assign len    = len_r;
  assign full   = (len_r == LW'(DEPTH));

endmodule

@@ sv/c_source_lexical_classifier_top.sv @@
// c_source_lexical_classifier_top: tags each C source byte with a lexical class.
// Depends on cslc_pkg and cslc_word_buf.
`timescale 1ns / 1ps
//
//   channel  direction  handshake            payload
//   in       input      in_valid / in_stall  in_byte, in_end_of_text
//   out      output     out_valid/out_stall  out_byte, out_byte_class, out_last_of_run
//
// An item is taken into an input register and its results go one per cycle into
// an output register while the output does not stall, so items with one result
// stream back to back. A held word of L bytes is released one byte a cycle while
// the output does not stall; the byte that ends it waits until the word is out, or
// goes with the last byte released when it is a slash or the end of text. A lone
// or comment-opening slash pair is placed slash first. Reset is synchronous
// on rst_n and clears control state. A stall on the output holds the output register,
// and the input stalls only while the current item still has results to place.

module c_source_lexical_classifier_top #(
  parameter int WORD_HOLD_DEPTH = 8
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_byte,
  input  logic       in_end_of_text,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] out_byte,
  output logic [2:0] out_byte_class,
  output logic       out_last_of_run
);
  import cslc_pkg::*;

  localparam int LW = $clog2(WORD_HOLD_DEPTH + 1);

  // input register
  logic       item_vld_r, item_vld_nxt;
  logic [7:0] item_byte_r;
  logic       item_eot_r;

  // lexer state
  mode_e      mode_r, mode_nxt;
  logic       ls_r, ls_nxt;
  logic       rel_busy_r, rel_busy_nxt;
  logic [2:0] rel_cls_r, rel_cls_nxt;
  logic       slash_ph_r, slash_ph_nxt;

  // output register
  logic       out_valid_r, out_valid_nxt;
  logic [7:0] out_byte_r;
  logic [2:0] out_cls_r;
  logic       out_last_r;

  // word buffer
  word_ctl_t     wctl;
  logic [7:0]    w_head;
  logic [LW-1:0] w_len;
  logic          w_full;
  logic          w_kw;

  // step decode
  logic       alnum, rel_now, slot_free, fire, done, in_xfer;
  logic       em, em_last;
  logic [7:0] em_byte;
  logic [2:0] em_cls, first_cls;
  mode_e      mode_cand;
  other_t     oth;

  cslc_word_buf #(
    .DEPTH(WORD_HOLD_DEPTH)
  ) u_word_buf (
    .clk    (clk),
    .rst_n  (rst_n),
    .ctl    (wctl),
    .wr_byte(item_byte_r),
    .head   (w_head),
    .len    (w_len),
    .full   (w_full),
    .kw_hit (w_kw)
  );

  assign alnum     = is_alnum(item_byte_r);
  assign oth       = normal_other(item_byte_r, ls_r);
  assign slot_free = !out_valid_r || !out_stall;
  assign first_cls = (item_eot_r || !alnum) ? (w_kw ? CLS_KEYWORD : CLS_PLAIN) : CLS_PLAIN;
  assign rel_now   = rel_busy_r || (w_len != '0 && (item_eot_r ||
                     (mode_r == MODE_NORMAL && (!alnum || w_full))));

  // one result step for the item in the input register
  always_comb begin
    em           = 1'b0;
    em_byte      = item_byte_r;
    em_cls       = CLS_PLAIN;
    em_last      = 1'b1;
    mode_cand    = mode_r;
    mode_nxt     = mode_r;
    ls_nxt       = ls_r;
    rel_busy_nxt = rel_busy_r;
    rel_cls_nxt  = rel_cls_r;
    slash_ph_nxt = slash_ph_r;
    wctl         = '0;
    fire         = 1'b0;
    done         = 1'b0;
    if (item_vld_r) begin
      if (rel_now) begin
        // release held word, head first
        em        = 1'b1;
        em_byte   = w_head;
        em_cls    = rel_busy_r ? rel_cls_r : first_cls;
        em_last   = (w_len == LW'(1)) && (item_eot_r || item_byte_r == CH_SLASH);
        mode_cand = item_eot_r ? MODE_NORMAL : MODE_SLASH;
        fire      = slot_free;
        if (fire) begin
          wctl.shift   = 1'b1;
          rel_busy_nxt = (w_len != LW'(1));
          rel_cls_nxt  = em_cls;
          if (!rel_busy_r && !item_eot_r && alnum) begin
            mode_nxt = MODE_LONG;
          end
        end
      end else if (item_eot_r) begin
        // flush a pending slash
        em        = (mode_r == MODE_SLASH);
        em_byte   = CH_SLASH;
        mode_cand = MODE_NORMAL;
      end else begin
        unique case (mode_r)
          MODE_LONG: begin
            if (alnum) begin
              em        = 1'b1;
              mode_cand = MODE_LONG;
            end else begin
              em        = oth.emit;
              em_cls    = oth.cls;
              mode_cand = oth.mode;
            end
          end
          MODE_SLASH: begin
            em     = 1'b1;
            em_cls = (item_byte_r == CH_STAR || item_byte_r == CH_SLASH) ?
                     CLS_COMMENT : CLS_PLAIN;
            if (!slash_ph_r) begin
              em_byte = CH_SLASH;
              em_last = 1'b0;
              if (slot_free) begin
                slash_ph_nxt = 1'b1;
              end
            end else if (item_byte_r == CH_STAR) begin
              mode_cand = MODE_BLOCK;
            end else if (item_byte_r == CH_SLASH) begin
              mode_cand = MODE_LINE;
            end else begin
              mode_cand = MODE_NORMAL;
            end
          end
          MODE_CHAR: begin
            em     = 1'b1;
            em_cls = CLS_CHAR;
            if (item_byte_r == CH_BSLASH) begin
              mode_cand = MODE_CHAR_ESC;
            end else if (item_byte_r == CH_SQUOTE) begin
              mode_cand = MODE_NORMAL;
            end
          end
          MODE_CHAR_ESC: begin
            em        = 1'b1;
            em_cls    = CLS_CHAR;
            mode_cand = MODE_CHAR;
          end
          MODE_STR: begin
            em     = 1'b1;
            em_cls = CLS_STRING;
            if (item_byte_r == CH_BSLASH) begin
              mode_cand = MODE_STR_ESC;
            end else if (item_byte_r == CH_DQUOTE) begin
              mode_cand = MODE_NORMAL;
            end
          end
          MODE_STR_ESC: begin
            em        = 1'b1;
            em_cls    = CLS_STRING;
            mode_cand = MODE_STR;
          end
          MODE_PRE: begin
            em     = 1'b1;
            em_cls = CLS_PRE;
            if (item_byte_r == CH_NL) begin
              mode_cand = MODE_NORMAL;
            end
          end
          MODE_BLOCK: begin
            em     = 1'b1;
            em_cls = CLS_COMMENT;
            if (item_byte_r == CH_STAR) begin
              mode_cand = MODE_BLOCK_STAR;
            end
          end
          MODE_BLOCK_STAR: begin
            em     = 1'b1;
            em_cls = CLS_COMMENT;
            if (item_byte_r == CH_SLASH) begin
              mode_cand = MODE_NORMAL;
            end else if (item_byte_r != CH_STAR) begin
              mode_cand = MODE_BLOCK;
            end
          end
          MODE_LINE: begin
            em     = 1'b1;
            em_cls = CLS_COMMENT;
            if (item_byte_r == CH_NL) begin
              mode_cand = MODE_NORMAL;
            end
          end
          default: begin
            mode_cand = MODE_NORMAL;
            if (alnum) begin
              wctl.append = 1'b1;
            end else begin
              em        = oth.emit;
              em_cls    = oth.cls;
              mode_cand = oth.mode;
            end
          end
        endcase
        fire = em && slot_free;
      end
      if (item_eot_r && !rel_now) begin
        fire = em && slot_free;
      end

      // item complete: commit mode and line-start flag
      done = em ? (fire && em_last) : 1'b1;
      if (done) begin
        mode_nxt     = mode_cand;
        slash_ph_nxt = 1'b0;
        rel_busy_nxt = 1'b0;
        if (item_eot_r) begin
          ls_nxt     = 1'b1;
          wctl.clear = 1'b1;
        end else begin
          ls_nxt = (item_byte_r == CH_NL);
        end
      end
    end
  end

  // input handshake
  assign in_stall     = item_vld_r && !done;
  assign in_xfer      = in_valid && !in_stall;
  assign item_vld_nxt = in_xfer ? 1'b1 : (done ? 1'b0 : item_vld_r);

  // output register occupancy
  assign out_valid_nxt = fire ? 1'b1 : (out_stall ? out_valid_r : 1'b0);

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      item_vld_r  <= 1'b0;
      mode_r      <= MODE_NORMAL;
      ls_r        <= 1'b1;
      rel_busy_r  <= 1'b0;
      rel_cls_r   <= CLS_PLAIN;
      slash_ph_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      item_vld_r  <= item_vld_nxt;
      mode_r      <= mode_nxt;
      ls_r        <= ls_nxt;
      rel_busy_r  <= rel_busy_nxt;
      rel_cls_r   <= rel_cls_nxt;
      slash_ph_r  <= slash_ph_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      item_byte_r <= in_byte;
      item_eot_r  <= in_end_of_text;
    end
    if (fire) begin
      out_byte_r <= em_byte;
      out_cls_r  <= em_cls;
      out_last_r <= em_last;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_byte        = out_byte_r;
  assign out_byte_class  = out_cls_r;
  assign out_last_of_run = out_last_r;

endmodule
